@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// clocked concurrent checks, disabled while the active-low reset is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: property check failed");

// condition must never be true at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

@@ rtl/core/twrtc_pkg.sv @@
// ----------------------------------------------------------------------------
// twrtc_pkg
// types, codes and bcd helpers for the three-wire rtc serial master
// ----------------------------------------------------------------------------
package twrtc_pkg;

    // request codes
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    // link phase codes
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_CMD_HI = 3'd1;
    localparam logic [2:0] PH_CMD_LO = 3'd2;
    localparam logic [2:0] PH_WR_HI  = 3'd3;
    localparam logic [2:0] PH_WR_LO  = 3'd4;
    localparam logic [2:0] PH_RD_LO  = 3'd5;
    localparam logic [2:0] PH_RD_SMP = 3'd6;

    localparam logic [7:0] TENS_MASK = 8'h70;
    localparam logic [7:0] ONES_MASK = 8'h0F;
    localparam logic [7:0] BIT_MASK  = 8'h01;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] command_byte;
        logic [7:0] write_value;
        logic       io_in;
    } t_req;

    typedef struct packed {
        logic       enable_line;
        logic       clock_line;
        logic       io_out;
        logic       io_drive;
        logic       busy_res;
        logic       done_res;
        logic [6:0] read_value;
        logic       rejected;
    } t_res;

    typedef struct packed {
        logic [2:0] phase;
        logic [3:0] bit_count;
        logic [7:0] out_shift;
        logic [7:0] pending_data;
        logic [7:0] in_shift;
        logic       is_write;
        logic [6:0] last_read;
    } t_state;

    // decimal to bcd, saturated at 99; divide by ten via reciprocal 205/2048
    function automatic logic [7:0] f_to_bcd(input logic [7:0] v);
        logic [6:0]  sat;
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  tens_x10;
        logic [6:0]  rem;
        sat      = (v > 8'd99) ? 7'd99 : v[6:0];
        prod     = 15'(sat) * 15'd205;
        tens     = prod[14:11];
        tens_x10 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
        rem      = sat - tens_x10;
        return {tens, rem[3:0]};
    endfunction

    // bcd to decimal with tens masked to three bits
    function automatic logic [6:0] f_from_bcd(input logic [7:0] b);
        logic [7:0] tens_b;
        logic [7:0] ones_b;
        logic [2:0] tens;
        tens_b = (b & TENS_MASK) >> 4;
        ones_b = b & ONES_MASK;
        tens   = tens_b[2:0];
        return 7'({tens, 3'b000}) + 7'({tens, 1'b0}) + 7'(ones_b[3:0]);
    endfunction

endpackage

@@ rtl/core/twrtc_if.sv @@
// ----------------------------------------------------------------------------
// twrtc_if
// valid/ready channels for request items and result items
// ----------------------------------------------------------------------------
interface twrtc_req_if import twrtc_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface twrtc_res_if import twrtc_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/twrtc_step.sv @@
// ----------------------------------------------------------------------------
// twrtc_step
// next-state and result logic for one request item
// ----------------------------------------------------------------------------
module twrtc_step import twrtc_pkg::*; (
    input  t_state i_state,
    input  t_req   i_req,
    output t_state o_state,
    output t_res   o_res
);

    t_state     n_state;
    logic [3:0] cnt_inc;
    logic       done;
    logic       rej;
    logic       drive;
    logic       clk_lvl;

    assign cnt_inc = i_state.bit_count + 4'd1;

    always_comb begin
        n_state = i_state;
        done    = 1'b0;
        rej     = 1'b0;
        if (i_req.req_type inside {REQ_READ, REQ_WRITE}) begin
            if (i_state.phase != PH_IDLE) begin
                rej = 1'b1;
            end else begin
                n_state.is_write     = (i_req.req_type == REQ_WRITE);
                n_state.out_shift    = i_req.command_byte;
                n_state.pending_data = f_to_bcd(i_req.write_value);
                n_state.bit_count    = 4'd0;
                n_state.phase        = PH_CMD_HI;
            end
        end else if (i_req.req_type == REQ_TICK) begin
            case (i_state.phase)
                PH_IDLE: begin
                end
                PH_CMD_HI: begin
                    n_state.phase = PH_CMD_LO;
                end
                PH_WR_HI: begin
                    n_state.phase = PH_WR_LO;
                end
                PH_CMD_LO: begin
                    n_state.out_shift = i_state.out_shift >> 1;
                    n_state.bit_count = cnt_inc;
                    if (cnt_inc < BITS_PER_BYTE) begin
                        n_state.phase = PH_CMD_HI;
                    end else if (i_state.is_write) begin
                        n_state.out_shift = i_state.pending_data;
                        n_state.bit_count = 4'd0;
                        n_state.phase     = PH_WR_HI;
                    end else begin
                        n_state.in_shift  = 8'd0;
                        n_state.bit_count = 4'd0;
                        n_state.phase     = PH_RD_SMP;
                    end
                end
                PH_WR_LO: begin
                    n_state.out_shift = i_state.out_shift >> 1;
                    n_state.bit_count = cnt_inc;
                    if (cnt_inc < BITS_PER_BYTE) begin
                        n_state.phase = PH_WR_HI;
                    end else begin
                        n_state.bit_count = 4'd0;
                        n_state.phase     = PH_IDLE;
                        done              = 1'b1;
                    end
                end
                PH_RD_LO: begin
                    n_state.phase = PH_RD_SMP;
                end
                PH_RD_SMP: begin
                    n_state.in_shift  = {i_req.io_in, i_state.in_shift[7:1]};
                    n_state.bit_count = cnt_inc;
                    if (cnt_inc < BITS_PER_BYTE) begin
                        n_state.phase = PH_RD_LO;
                    end else begin
                        n_state.last_read = f_from_bcd({i_req.io_in, i_state.in_shift[7:1]});
                        n_state.bit_count = 4'd0;
                        n_state.phase     = PH_IDLE;
                        done              = 1'b1;
                    end
                end
                default: begin
                    n_state.phase = PH_IDLE;
                end
            endcase
        end
    end

    assign drive   = (n_state.phase == PH_CMD_HI) || (n_state.phase == PH_CMD_LO) ||
                     (n_state.phase == PH_WR_HI)  || (n_state.phase == PH_WR_LO);
    assign clk_lvl = (n_state.phase == PH_CMD_LO) || (n_state.phase == PH_WR_LO) ||
                     (n_state.phase == PH_RD_LO);

    assign o_state = n_state;

    always_comb begin
        o_res.enable_line = (n_state.phase != PH_IDLE);
        o_res.clock_line  = clk_lvl;
        o_res.io_out      = drive & n_state.out_shift[0];
        o_res.io_drive    = drive;
        o_res.busy_res    = (n_state.phase != PH_IDLE);
        o_res.done_res    = done;
        o_res.read_value  = n_state.last_read;
        o_res.rejected    = rej;
    end

endmodule

@@ rtl/core/three_wire_rtc_serial_master_core.sv @@
// ----------------------------------------------------------------------------
// three_wire_rtc_serial_master_core
// half-bit-stepped master for a three-wire rtc serial link
// ----------------------------------------------------------------------------
// usage
//   i_req carries one request item per transaction: a tick (one half bit
//   time of the link), a start read or a start write, plus the command
//   byte, the decimal write value and the sampled data line level.
//   o_res returns exactly one result item per request: enable, clock and
//   data line levels, drive enable, busy, done, last read value, rejected.
// throughput
//   a request sits in the input register and its result lands in the
//   output register when the step advances, which a stall on o_res can delay.
//   one request per cycle is sustained while o_res is not held off; the step
//   logic is a single pass from the input register to the output register.
// reset
//   i_rst_n low (synchronous) empties both registers and returns the link
//   to idle with all counters, shift registers and the read value at zero.
// stall
//   while o_res is held off the result stays put; one more request can be
//   taken into the input register, after which i_req.ready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module three_wire_rtc_serial_master_core import twrtc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    twrtc_req_if.sink         i_req,
    twrtc_res_if.source       o_res
);

    // input register
    logic   r_in_vld;
    t_req   r_in;

    // link state
    t_state r_state;
    t_state n_state;

    // output register
    logic   r_out_vld;
    t_res   r_res;
    t_res   n_res;

    logic   adv;

    // step the held request when the output slot is free or being drained
    assign adv         = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_req.ready = !r_in_vld || adv;

    twrtc_step u_step (
        .i_state (r_state),
        .i_req   (r_in),
        .o_state (n_state),
        .o_res   (n_res)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                r_in_vld <= 1'b1;
            end else if (adv) begin
                r_in_vld <= 1'b0;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
                r_state   <= n_state;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in <= i_req.data;
        end
        if (adv) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_res;

    // idle always leaves the bit counter cleared
    `ASSERT_NEVER(a_idle_count_clear, i_clk, i_rst_n,
        (r_state.phase == PH_IDLE) && (r_state.bit_count != 4'd0))
    // counter never holds a full byte between steps
    `ASSERT_NEVER(a_count_range, i_clk, i_rst_n, r_state.bit_count > 4'd7)
    // the ending item reports not busy
    `ASSERT_NEVER(a_done_not_busy, i_clk, i_rst_n,
        r_out_vld && r_res.done_res && r_res.busy_res)
    // a rejected request only happens mid-transaction
    `ASSERT_NEVER(a_reject_busy, i_clk, i_rst_n,
        r_out_vld && r_res.rejected && !r_res.busy_res)
    // a stepped request always yields a valid result on the next edge
    `ASSERT_PROP(a_step_result, i_clk, i_rst_n, adv |=> r_out_vld)

endmodule

@@ test/three_wire_rtc_serial_master_core_tb.sv @@
// ----------------------------------------------------------------------------
// three_wire_rtc_serial_master_core_tb
// self-checking bench for the three-wire rtc serial master core: requests
// are driven in random bursts, results are taken under a varying stall
// pattern and compared field by field with a cycle-free model of the link
// ----------------------------------------------------------------------------
module three_wire_rtc_serial_master_core_tb;
    import twrtc_pkg::*;

    // request code the block leaves unused, must be ignored
    localparam logic [1:0] REQ_NONE = 2'd3;

    // io_in source for the ticks of a link transfer
    localparam int IO_ZEROS  = 0;
    localparam int IO_ONES   = 1;
    localparam int IO_RANDOM = 2;

    localparam int RANDOM_ITEMS  = 350;
    localparam int STALL_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int LONG_HOLD     = 120;
    localparam int HOLD_AT_COUNT = 300;

    // ------------------------------------------------------------------------
    // link model and store of expected line levels
    // ------------------------------------------------------------------------
    class rtc_link_model;
        logic [2:0] phase;
        logic [3:0] bit_cnt;
        logic [7:0] out_sr;
        logic [7:0] wr_bcd;
        logic [7:0] in_sr;
        logic       is_wr;
        logic [6:0] read_dec;
        t_res       expected_levels[$];
        int unsigned errors;

        function new();
            phase    = PH_IDLE;
            bit_cnt  = '0;
            out_sr   = '0;
            wr_bcd   = '0;
            in_sr    = '0;
            is_wr    = 1'b0;
            read_dec = '0;
            errors   = 0;
        endfunction

        function logic [7:0] dec_to_bcd(logic [7:0] v);
            int s;
            s = (v > 99) ? 99 : int'(v);
            return {4'(s / 10), 4'(s % 10)};
        endfunction

        function logic [6:0] bcd_to_dec(logic [7:0] b);
            int tens;
            int ones;
            tens = (b >> 4) & 7;
            ones = b & 15;
            return 7'(tens * 10 + ones);
        endfunction

        function bit busy();
            return phase != PH_IDLE;
        endfunction

        function int unsigned pending();
            return expected_levels.size();
        endfunction

        // advance the link by one accepted request and queue the levels it leaves
        function void note_request(t_req r);
            t_res lv;
            bit   done_now;
            bit   rej_now;
            bit   drive;
            bit   clk_hi;
            done_now = 1'b0;
            rej_now  = 1'b0;
            if (r.req_type == REQ_READ || r.req_type == REQ_WRITE) begin
                if (phase != PH_IDLE) begin
                    rej_now = 1'b1;
                end else begin
                    is_wr   = (r.req_type == REQ_WRITE);
                    out_sr  = r.command_byte;
                    wr_bcd  = dec_to_bcd(r.write_value);
                    bit_cnt = '0;
                    phase   = PH_CMD_HI;
                end
            end else if (r.req_type == REQ_TICK) begin
                case (phase)
                    PH_CMD_HI: phase = PH_CMD_LO;
                    PH_WR_HI:  phase = PH_WR_LO;
                    PH_RD_LO:  phase = PH_RD_SMP;
                    PH_CMD_LO: begin
                        out_sr  = out_sr >> 1;
                        bit_cnt = bit_cnt + 4'd1;
                        if (bit_cnt < BITS_PER_BYTE) begin
                            phase = PH_CMD_HI;
                        end else if (is_wr) begin
                            out_sr  = wr_bcd;
                            bit_cnt = '0;
                            phase   = PH_WR_HI;
                        end else begin
                            in_sr   = '0;
                            bit_cnt = '0;
                            phase   = PH_RD_SMP;
                        end
                    end
                    PH_WR_LO: begin
                        out_sr  = out_sr >> 1;
                        bit_cnt = bit_cnt + 4'd1;
                        if (bit_cnt < BITS_PER_BYTE) begin
                            phase = PH_WR_HI;
                        end else begin
                            bit_cnt  = '0;
                            phase    = PH_IDLE;
                            done_now = 1'b1;
                        end
                    end
                    PH_RD_SMP: begin
                        in_sr   = {r.io_in, in_sr[7:1]};
                        bit_cnt = bit_cnt + 4'd1;
                        if (bit_cnt < BITS_PER_BYTE) begin
                            phase = PH_RD_LO;
                        end else begin
                            read_dec = bcd_to_dec(in_sr);
                            bit_cnt  = '0;
                            phase    = PH_IDLE;
                            done_now = 1'b1;
                        end
                    end
                    default: phase = PH_IDLE;
                endcase
            end

            drive  = (phase == PH_CMD_HI || phase == PH_CMD_LO ||
                      phase == PH_WR_HI || phase == PH_WR_LO);
            clk_hi = (phase == PH_CMD_LO || phase == PH_WR_LO || phase == PH_RD_LO);

            lv.enable_line = (phase != PH_IDLE);
            lv.clock_line  = clk_hi;
            lv.io_out      = drive ? out_sr[0] : 1'b0;
            lv.io_drive    = drive;
            lv.busy_res    = (phase != PH_IDLE);
            lv.done_res    = done_now;
            lv.read_value  = read_dec;
            lv.rejected    = rej_now;
            expected_levels.push_back(lv);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        // compare one accepted result with the oldest expectation
        function void check_levels(t_res got);
            t_res want;
            if (expected_levels.size() == 0) begin
                $error("result with no expectation waiting: %h", got);
                errors++;
                return;
            end
            want = expected_levels.pop_front();
            compare_field("enable_line", 8'(want.enable_line), 8'(got.enable_line));
            compare_field("clock_line",  8'(want.clock_line),  8'(got.clock_line));
            compare_field("io_out",      8'(want.io_out),      8'(got.io_out));
            compare_field("io_drive",    8'(want.io_drive),    8'(got.io_drive));
            compare_field("busy_res",    8'(want.busy_res),    8'(got.busy_res));
            compare_field("done_res",    8'(want.done_res),    8'(got.done_res));
            compare_field("read_value",  8'(want.read_value),  8'(got.read_value));
            compare_field("rejected",    8'(want.rejected),    8'(got.rejected));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic i_clk;
    logic i_rst_n;

    twrtc_req_if req_ch();
    twrtc_res_if res_ch();

    three_wire_rtc_serial_master_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source)
    );

    rtc_link_model link_model = new();

    int unsigned items_sent;
    int unsigned burst_left;
    int unsigned results_seen = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------
    function automatic t_req make_request(logic [1:0] kind, logic [7:0] cmd,
                                          logic [7:0] val, logic io);
        t_req r;
        r.req_type     = kind;
        r.command_byte = cmd;
        r.write_value  = val;
        r.io_in        = io;
        return r;
    endfunction

    // offer one request, with a random gap between bursts; valid stays high
    // after the transaction so back-to-back requests need no extra edge
    task automatic send_item(t_req r);
        if (burst_left == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(60, 120)
                                                  : $urandom_range(1, 20);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        link_model.note_request(r);
        items_sent++;
        burst_left--;
    endtask

    // sender pause until every expected result has come back
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (link_model.pending() != 0);
    endtask

    function automatic t_req random_noise();
        logic [1:0] kind;
        case ($urandom_range(2))
            0:       kind = REQ_READ;
            1:       kind = REQ_WRITE;
            default: kind = REQ_NONE;
        endcase
        return make_request(kind, 8'($urandom), 8'($urandom), 1'($urandom));
    endfunction

    // tick the link until the transfer ends, with stray requests mixed in
    task automatic finish_transfer(int io_mode, int noise_pct);
        logic io;
        while (link_model.busy()) begin
            if ($urandom_range(99) < noise_pct) begin
                send_item(random_noise());
            end else begin
                case (io_mode)
                    IO_ZEROS: io = 1'b0;
                    IO_ONES:  io = 1'b1;
                    default:  io = 1'($urandom);
                endcase
                send_item(make_request(REQ_TICK, 8'($urandom), 8'($urandom), io));
            end
        end
    endtask

    task automatic run_transfer(logic [1:0] kind, logic [7:0] cmd, logic [7:0] val,
                                int io_mode, int noise_pct);
        send_item(make_request(kind, cmd, val, 1'b0));
        finish_transfer(io_mode, noise_pct);
    endtask

    function automatic logic [7:0] random_write_value();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return 8'($urandom_range(0, 99));
            5, 6, 7:       return 8'($urandom_range(100, 255));
            default:       return 8'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned directed_count;
        bit          paused;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        i_rst_n      <= 1'b0;
        items_sent   = 0;
        burst_left   = 0;
        paused       = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // tick and unused code while idle change nothing
        send_item(make_request(REQ_TICK, 8'hFF, 8'hFF, 1'b1));
        send_item(make_request(REQ_NONE, 8'hFF, 8'hFF, 1'b1));

        // write with saturated value; requests and unused code while busy
        send_item(make_request(REQ_WRITE, 8'hFF, 8'hFF, 1'b0));
        send_item(make_request(REQ_TICK, 8'h00, 8'h00, 1'b0));
        send_item(make_request(REQ_READ, 8'h00, 8'h00, 1'b0));
        send_item(make_request(REQ_WRITE, 8'h00, 8'h00, 1'b0));
        send_item(make_request(REQ_NONE, 8'h00, 8'h00, 1'b1));
        finish_transfer(IO_RANDOM, 0);

        // write value extremes around the saturation point
        run_transfer(REQ_WRITE, 8'h00, 8'd99, IO_RANDOM, 0);
        run_transfer(REQ_WRITE, 8'h80, 8'd100, IO_RANDOM, 0);
        run_transfer(REQ_WRITE, 8'h5A, 8'd0, IO_RANDOM, 0);

        // read of all ones drops the top tens bit; read of all zeros
        run_transfer(REQ_READ, 8'h81, 8'h00, IO_ONES, 0);
        run_transfer(REQ_READ, 8'h01, 8'hFF, IO_ZEROS, 0);
        directed_count = items_sent;

        // random part: mostly well-formed transfers with random content
        while (items_sent - directed_count < RANDOM_ITEMS) begin
            if (!paused && items_sent - directed_count > RANDOM_ITEMS / 2) begin
                drain_results();
                paused = 1'b1;
            end
            if ($urandom_range(99) < 85) begin
                run_transfer($urandom_range(1) ? REQ_WRITE : REQ_READ, 8'($urandom),
                             random_write_value(), IO_RANDOM, 5);
            end else begin
                // idle noise: ticks, unused code or back-to-back starts
                if ($urandom_range(1))
                    send_item(make_request(REQ_TICK, 8'($urandom), 8'($urandom),
                                           1'($urandom)));
                else
                    send_item(random_noise());
            end
        end

        // wait for every expected result, then let the pipeline settle
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (link_model.errors == 0 && link_model.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // result side: stall pattern, one long hold-off, checking
    // ------------------------------------------------------------------------
    int unsigned rx_cycle = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    always @(posedge i_clk) begin
        logic next_ready;
        if (i_rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            link_model.check_levels(res_ch.data);
            results_seen++;
        end
        rx_cycle++;

        // hold off long enough that both pipeline registers fill
        if (!hold_done && results_seen >= HOLD_AT_COUNT) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
        end

        if (hold_left != 0) begin
            hold_left--;
            next_ready = 1'b0;
        end else begin
            // rotate between full rate, random stalls and a fixed pattern
            case ((rx_cycle >> 8) % 3)
                0:       next_ready = 1'b1;
                1:       next_ready = 1'($urandom);
                default: next_ready = ((rx_cycle % 5) >= 2);
            endcase
        end
        res_ch.ready <= next_ready;
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without any transaction on either channel
    // ------------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule
